FILE: rtl/core/slt_pkg.sv
// Shared types and codes for the source line tokenizer.
// Holds the item structs of both channels and the result bundle of one input item.
// No dependencies.
package slt_pkg;

  // Result slots per input item; a byte causes at most two tokens and the marker
  localparam int unsigned MaxRes = 4;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  kind_t;
  typedef logic [11:0] col_t;
  typedef logic [12:0] len_t;
  typedef logic [12:0] count_t;

  // Token kinds
  localparam kind_t KIND_COMMENT = 3'd0;
  localparam kind_t KIND_STRING  = 3'd1;
  localparam kind_t KIND_NUMBER  = 3'd2;
  localparam kind_t KIND_PREPROC = 3'd3;
  localparam kind_t KIND_OPER    = 3'd4;
  localparam kind_t KIND_IDENT   = 3'd5;

  typedef struct packed {
    byte_t char_byte;
    logic  line_end;
  } in_item_t;

  typedef struct packed {
    logic   is_token;
    kind_t  token_kind;
    col_t   start_col;
    len_t   token_len;
    logic   line_done;
    count_t token_total;
    logic   line_too_long;
  } out_item_t;

  // Results of one input item, packed from slot 0 upwards
  typedef struct packed {
    out_item_t [MaxRes-1:0] item;
    logic [2:0]             cnt;
  } burst_t;

endpackage

FILE: rtl/core/slt_scan.sv
// Line scanner: holds the per-line scan state and turns one byte into its results.
// Depends on slt_pkg for the item and result bundle types.
module slt_scan #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  slt_pkg::in_item_t     item_i,
  input  slt_pkg::count_t       max_tokens_i,
  output slt_pkg::burst_t       burst_o
);

  localparam int unsigned PW = $clog2(MAX_LINE);
  localparam int unsigned CW = $clog2(MAX_LINE + 1);

  localparam slt_pkg::byte_t ChSpace  = 8'h20;
  localparam slt_pkg::byte_t ChTab    = 8'h09;
  localparam slt_pkg::byte_t ChCr     = 8'h0d;
  localparam slt_pkg::byte_t ChSemi   = 8'h3b;
  localparam slt_pkg::byte_t ChSlash  = 8'h2f;
  localparam slt_pkg::byte_t ChZero   = 8'h30;
  localparam slt_pkg::byte_t ChDquote = 8'h22;
  localparam slt_pkg::byte_t ChSquote = 8'h27;
  localparam slt_pkg::byte_t ChHash   = 8'h23;
  localparam slt_pkg::byte_t ChDot    = 8'h2e;
  localparam slt_pkg::byte_t ChUnder  = 8'h5f;
  localparam slt_pkg::byte_t ChBslash = 8'h5c;
  localparam slt_pkg::byte_t ChLowX   = 8'h78;
  localparam slt_pkg::byte_t ChUpX    = 8'h58;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_DEC,
    MODE_FRAC,
    MODE_HEX,
    MODE_PREPROC,
    MODE_IDENT
  } mode_e;

  typedef struct packed {
    logic          v;
    slt_pkg::kind_t kind;
    logic [PW-1:0] start;
    logic [CW-1:0] len;
  } cand_t;

  function automatic logic is_digit(slt_pkg::byte_t b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(slt_pkg::byte_t b);
    return b inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_hex(slt_pkg::byte_t b);
    return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_word(slt_pkg::byte_t b);
    return is_alpha(b) || is_digit(b) || b == ChUnder || b == ChDot;
  endfunction

  // + - * / = < > ! & | ^ ~ ( ) [ ] { } , :
  function automatic logic is_op(slt_pkg::byte_t b);
    return b inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h3c, 8'h3e, 8'h21, 8'h26,
                     8'h7c, 8'h5e, 8'h7e, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d,
                     8'h2c, 8'h3a};
  endfunction

  function automatic slt_pkg::kind_t mode_kind(mode_e m);
    case (m)
      MODE_COMMENT:                   return slt_pkg::KIND_COMMENT;
      MODE_STRING, MODE_ESCAPE:       return slt_pkg::KIND_STRING;
      MODE_DEC, MODE_FRAC, MODE_HEX:  return slt_pkg::KIND_NUMBER;
      MODE_PREPROC:                   return slt_pkg::KIND_PREPROC;
      default:                        return slt_pkg::KIND_IDENT;
    endcase
  endfunction

  // Line state
  mode_e             mode_q, mode_d;
  logic              pend_q, pend_d;
  logic              slash_q, slash_d;
  slt_pkg::byte_t    quote_q, quote_d;
  logic [CW-1:0]     col_q, col_d;
  logic [PW-1:0]     tstart_q, tstart_d;
  slt_pkg::count_t   tcount_q, tcount_d;
  logic              ovf_q, ovf_d;

  // Step temporaries
  slt_pkg::byte_t    b;
  logic [PW-1:0]     pos;
  logic [CW-1:0]     after;
  logic              handled;
  logic              disp;
  cand_t             cand_a, cand_b, cand_c;
  cand_t [2:0]       cands;
  slt_pkg::count_t   cnt;
  logic [2:0]        nres;
  slt_pkg::out_item_t [slt_pkg::MaxRes-1:0] res;

  always_comb begin
    b        = item_i.char_byte;
    pos      = (col_q >= CW'(MAX_LINE - 1)) ? PW'(MAX_LINE - 1) : PW'(col_q);
    after    = (col_q == CW'(MAX_LINE)) ? col_q : col_q + 1'b1;
    ovf_d    = ovf_q | (col_q == CW'(MAX_LINE));
    mode_d   = mode_q;
    pend_d   = pend_q;
    slash_d  = slash_q;
    quote_d  = quote_q;
    tstart_d = tstart_q;
    handled  = 1'b0;
    disp     = 1'b0;
    cand_a   = '0;
    cand_b   = '0;
    cand_c   = '0;

    // Resolve a held '/' or '0' against this byte
    if (pend_q) begin
      pend_d = 1'b0;
      if (slash_q) begin
        handled = 1'b1;
        if (b == ChSlash) begin
          mode_d = MODE_COMMENT;
        end else begin
          cand_a = '{v: 1'b1, kind: slt_pkg::KIND_OPER, start: tstart_q, len: CW'(1)};
          disp   = 1'b1;
        end
      end else if (b == ChLowX || b == ChUpX) begin
        mode_d  = MODE_HEX;
        handled = 1'b1;
      end else begin
        mode_d = MODE_DEC;
      end
    end

    // Advance the current token
    if (!handled) begin
      case (mode_d)
        MODE_COMMENT: begin
        end
        MODE_STRING: begin
          if (b == quote_q) begin
            cand_a = '{v: 1'b1, kind: slt_pkg::KIND_STRING, start: tstart_q,
                       len: after - CW'(tstart_q)};
            mode_d = MODE_IDLE;
          end else if (b == ChBslash) begin
            mode_d = MODE_ESCAPE;
          end
        end
        MODE_ESCAPE: begin
          mode_d = MODE_STRING;
        end
        MODE_DEC, MODE_FRAC: begin
          if (is_digit(b)) begin
          end else if (mode_d == MODE_DEC && b == ChDot) begin
            mode_d = MODE_FRAC;
          end else begin
            cand_a = '{v: 1'b1, kind: slt_pkg::KIND_NUMBER, start: tstart_q,
                       len: col_q - CW'(tstart_q)};
            disp   = 1'b1;
          end
        end
        MODE_HEX: begin
          if (!is_hex(b)) begin
            cand_a = '{v: 1'b1, kind: slt_pkg::KIND_NUMBER, start: tstart_q,
                       len: col_q - CW'(tstart_q)};
            disp   = 1'b1;
          end
        end
        MODE_PREPROC: begin
          if (b == ChSpace || b == ChTab) begin
            cand_a = '{v: 1'b1, kind: slt_pkg::KIND_PREPROC, start: tstart_q,
                       len: col_q - CW'(tstart_q)};
            mode_d = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (!is_word(b)) begin
            cand_a = '{v: 1'b1, kind: slt_pkg::KIND_IDENT, start: tstart_q,
                       len: col_q - CW'(tstart_q)};
            disp   = 1'b1;
          end
        end
        default: begin
          disp = 1'b1;
        end
      endcase
    end

    // Start a new token from this byte
    if (disp) begin
      mode_d = MODE_IDLE;
      if (!(b == ChSpace || b == ChTab || b == ChCr)) begin
        tstart_d = pos;
        if (b == ChSemi) begin
          mode_d = MODE_COMMENT;
        end else if (b == ChSlash || b == ChZero) begin
          pend_d  = 1'b1;
          slash_d = (b == ChSlash);
        end else if (b == ChDquote || b == ChSquote) begin
          quote_d = b;
          mode_d  = MODE_STRING;
        end else if (is_digit(b)) begin
          mode_d = MODE_DEC;
        end else if (b == ChHash) begin
          mode_d = MODE_PREPROC;
        end else if (is_op(b)) begin
          cand_b = '{v: 1'b1, kind: slt_pkg::KIND_OPER, start: pos, len: CW'(1)};
        end else if (is_alpha(b) || b == ChUnder || b == ChDot) begin
          mode_d = MODE_IDENT;
        end else begin
          cand_b = '{v: 1'b1, kind: slt_pkg::KIND_IDENT, start: pos, len: CW'(1)};
        end
      end
    end

    col_d = after;

    // Flush an open token at the end of the line
    if (item_i.line_end) begin
      if (pend_d) begin
        cand_c = '{v: 1'b1,
                   kind: slash_d ? slt_pkg::KIND_OPER : slt_pkg::KIND_NUMBER,
                   start: tstart_d, len: after - CW'(tstart_d)};
      end else if (mode_d != MODE_IDLE) begin
        cand_c = '{v: 1'b1, kind: mode_kind(mode_d), start: tstart_d,
                   len: after - CW'(tstart_d)};
      end
    end

    // Pack tokens under the per-line limit, then the marker
    cands = {cand_c, cand_b, cand_a};
    cnt   = tcount_q;
    nres  = '0;
    res   = '0;
    for (int k = 0; k < 3; k++) begin
      if (cands[k].v && cnt < max_tokens_i) begin
        res[nres[1:0]] = '{is_token: 1'b1, token_kind: cands[k].kind,
                           start_col: slt_pkg::col_t'(cands[k].start),
                           token_len: slt_pkg::len_t'(cands[k].len),
                           line_done: 1'b0, token_total: '0, line_too_long: 1'b0};
        nres = nres + 3'd1;
        cnt  = cnt + 1'b1;
      end
    end
    if (item_i.line_end) begin
      res[nres[1:0]] = '{is_token: 1'b0, token_kind: '0, start_col: '0, token_len: '0,
                         line_done: 1'b1, token_total: cnt, line_too_long: ovf_d};
      nres = nres + 3'd1;
    end
    tcount_d = cnt;

    burst_o.item = res;
    burst_o.cnt  = nres;
  end

  // Hold line state; clear it after the marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= 1'b0;
      slash_q  <= 1'b0;
      quote_q  <= '0;
      col_q    <= '0;
      tstart_q <= '0;
      tcount_q <= '0;
      ovf_q    <= 1'b0;
    end else if (accept_i) begin
      if (item_i.line_end) begin
        mode_q   <= MODE_IDLE;
        pend_q   <= 1'b0;
        slash_q  <= 1'b0;
        quote_q  <= '0;
        col_q    <= '0;
        tstart_q <= '0;
        tcount_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        mode_q   <= mode_d;
        pend_q   <= pend_d;
        slash_q  <= slash_d;
        quote_q  <= quote_d;
        col_q    <= col_d;
        tstart_q <= tstart_d;
        tcount_q <= tcount_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

FILE: rtl/core/slt_out_queue.sv
// Result queue: eight-entry FIFO that takes up to four results per cycle, gives one.
// Depends on slt_pkg for the result item and bundle types.
module slt_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slt_pkg::burst_t     burst_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slt_pkg::out_item_t  out_data_o
);

  localparam int unsigned Depth = 2 * slt_pkg::MaxRes;
  localparam int unsigned AW    = $clog2(Depth);

  slt_pkg::out_item_t mem_q [Depth];
  logic [AW-1:0]      wr_q, wr_d;
  logic [AW-1:0]      rd_q, rd_d;
  logic [AW:0]        cnt_q, cnt_d;
  logic [2:0]         push_n;
  logic               pop;

  // Accept a new item only while a full burst still fits
  assign room_o      = cnt_q <= (AW + 1)'(Depth - slt_pkg::MaxRes);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = push_i ? burst_i.cnt : 3'd0;

  always_comb begin
    wr_d  = wr_q + AW'(push_n);
    rd_d  = rd_q + AW'(pop);
    cnt_d = cnt_q + (AW + 1)'(push_n) - (AW + 1)'(pop);
  end

  // Store the burst
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < slt_pkg::MaxRes; k++) begin
      if (push_i && 3'(k) < burst_i.cnt) begin
        mem_q[wr_q + AW'(k)] <= burst_i.item[k];
      end
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/source_line_tokenizer_unit.sv
// Source line tokenizer, top level: token limit register, line scanner, result queue.
// Depends on slt_pkg, slt_scan and slt_out_queue.
//
// Usage: feed one byte of a source line per in_data_i item, with line_end set on the
// last byte. Each byte gives zero to three results on out_data_o: highlighting tokens
// (kind, start column, length) in line order, and after the last byte one end-of-line
// marker with the token count and the long-line flag.
// The token limit is written through cfg_valid_i/cfg_data_i, which is always ready;
// write it only while no line is in flight. It resets to 4096.
// The results of a byte are written into the result queue when the byte is taken.
// Throughput: one byte per cycle while the result queue holds four entries or fewer;
// the output side drains one result per cycle, so bytes that close two tokens, or a
// stalled receiver, fill the queue and drop in_ready_o until it drains.
// A stalled receiver never loses results: they wait in the eight-entry queue.
// Reset empties the queue, clears the line state and sets the token limit to 4096.
module source_line_tokenizer_unit #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slt_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slt_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  slt_pkg::count_t     cfg_data_i
);

  slt_pkg::count_t max_tokens_q;
  slt_pkg::burst_t burst;
  logic            accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Hold the per-line token limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= slt_pkg::count_t'(4096);
    end else if (cfg_valid_i) begin
      max_tokens_q <= cfg_data_i;
    end
  end

  slt_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .max_tokens_i (max_tokens_q),
    .burst_o      (burst)
  );

  slt_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .burst_i     (burst),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
